[design/buc_pkg.sv]
// Shared widths, codes and structs for the Burgers upwind cell update.
// No dependencies; every other design file imports this package.
package buc_pkg;

   localparam int DATA_W     = 32;  // Q4.28 cell values
   localparam int CFG_W      = 31;  // courant and diffusion registers
   localparam int LAP_W      = 34;  // left - 2*center + right, signed
   localparam int SQ_W       = 64;  // square of a 32-bit magnitude
   localparam int ADDR_W     = 4;   // three registers at byte 0, 4, 8
   localparam int NUM_STAGES = 7;
   localparam int NUM_LANES  = 3;

   // first stage of each unit in the pipeline (0 is the input register)
   localparam int LANE_STAGE = 2;
   localparam int ACC_STAGE  = 5;

   // flux lane order
   localparam int LANE_LEFT   = 0;
   localparam int LANE_CENTER = 1;
   localparam int LANE_RIGHT  = 2;

   // center upwind factor codes
   localparam logic [1:0] FB_PLUS  = 2'd0;
   localparam logic [1:0] FB_MINUS = 2'd1;
   localparam logic [1:0] FB_ZERO  = 2'd2;

   typedef struct packed {
      logic [CFG_W-1:0] courant;
      logic [CFG_W-1:0] diffusion;
      logic             viscous_en;
   } cfg_type;

   typedef struct packed {
      logic [NUM_STAGES-1:0] en;
   } pipe_ctl_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] center;
      logic                     left_f;
      logic [1:0]               center_f;
      logic                     right_f;
      logic                     lap_neg;
   } side_type;

endpackage

[design/buc_req_if.sv]
// Input channel of the cell update: three old cell values per item.
// Depends on buc_pkg for the data width.
interface buc_req_if import buc_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] left_old;
   logic signed [DATA_W-1:0] center_old;
   logic signed [DATA_W-1:0] right_old;

   modport source (output valid, left_old, center_old, right_old, input ready);
   modport sink   (input valid, left_old, center_old, right_old, output ready);
endinterface

[design/buc_rsp_if.sv]
// Result channel of the cell update: new value, upwind factors, flag.
// Depends on buc_pkg for the data width.
interface buc_rsp_if import buc_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] new_value;
   logic                     left_factor;
   logic [1:0]               center_factor;
   logic                     right_factor;
   logic                     saturated;

   modport source (output valid, new_value, left_factor, center_factor, right_factor,
                   saturated, input ready);
   modport sink   (input valid, new_value, left_factor, center_factor, right_factor,
                   saturated, output ready);
endinterface

[design/buc_csr.sv]
// APB-style register block: courant number, diffusion number, viscous enable.
// Depends on buc_pkg for cfg_type and widths.
module buc_csr import buc_pkg::*; #(
   parameter int FRAC_BITS = 28
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready,
   output cfg_type           cfg
);

   localparam logic [1:0] REG_COURANT   = 2'd0;
   localparam logic [1:0] REG_DIFFUSION = 2'd1;
   localparam logic [1:0] REG_VISCOUS   = 2'd2;

   localparam logic [CFG_W-1:0] COURANT_RESET = CFG_W'(64'd1 << FRAC_BITS);

   cfg_type    cfg_ff, cfg_in;
   logic [1:0] index;
   logic       write_en;

   assign index    = paddr[ADDR_W-1:2];
   assign write_en = psel && penable && pwrite && pready;
   assign pready   = 1'b1;
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            REG_COURANT:   cfg_in.courant    = pwdata[CFG_W-1:0];
            REG_DIFFUSION: cfg_in.diffusion  = pwdata[CFG_W-1:0];
            REG_VISCOUS:   cfg_in.viscous_en = pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_COURANT:   prdata = {1'b0, cfg_ff.courant};
         REG_DIFFUSION: prdata = {1'b0, cfg_ff.diffusion};
         REG_VISCOUS:   prdata = {31'd0, cfg_ff.viscous_en};
         default:       prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.courant    <= COURANT_RESET;
         cfg_ff.diffusion  <= '0;
         cfg_ff.viscous_en <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[design/buc_scale_lane.sv]
// Three-stage unit: round(factor * operand / 2^SHIFT), half away from zero.
// The product is built from two partial products; depends on buc_pkg.
module buc_scale_lane import buc_pkg::*; #(
   parameter int B_W   = 64,
   parameter int SHIFT = 57,
   parameter int T_W   = 39
) (
   input  logic             clock,
   input  pipe_ctl_type     ctl,
   input  logic [CFG_W-1:0] factor,
   input  logic [B_W-1:0]   operand,
   output logic [T_W-1:0]   term
);

   localparam int LO_W  = 32;
   localparam int HI_W  = B_W - LO_W;
   localparam int LP_W  = CFG_W + LO_W;
   localparam int HP_W  = CFG_W + HI_W;
   localparam int P_W   = CFG_W + B_W;
   localparam int SUM_W = (P_W > SHIFT ? P_W : SHIFT) + 1;
   localparam logic [SUM_W-1:0] HALF = SUM_W'(1) << (SHIFT - 1);

   logic [LP_W-1:0]  lo_prod_ff, lo_prod_in, lo_hold_ff;
   logic [HI_W-1:0]  hi_op_ff;
   logic [HP_W-1:0]  hi_prod_ff, hi_prod_in;
   logic [SUM_W-1:0] sum_ff, sum_in, shifted;

   assign lo_prod_in = LP_W'(factor) * LP_W'(operand[LO_W-1:0]);
   assign hi_prod_in = HP_W'(factor) * HP_W'(hi_op_ff);
   assign sum_in     = SUM_W'(lo_hold_ff) + (SUM_W'(hi_prod_ff) << LO_W) + HALF;
   assign shifted    = sum_ff >> SHIFT;
   assign term       = shifted[T_W-1:0];

   always_ff @(posedge clock) begin
      if (ctl.en[LANE_STAGE]) begin
         lo_prod_ff <= lo_prod_in;
         hi_op_ff   <= operand[B_W-1:LO_W];
      end
      if (ctl.en[LANE_STAGE+1]) begin
         hi_prod_ff <= hi_prod_in;
         lo_hold_ff <= lo_prod_ff;
      end
      if (ctl.en[LANE_STAGE+2]) begin
         sum_ff <= sum_in;
      end
   end

endmodule

[design/buc_accum.sv]
// Signs and gates the four scaled terms, sums them with the center value and
// saturates to 32 bits over two stages. Depends on buc_pkg.
module buc_accum import buc_pkg::*; #(
   parameter int FLUX_TW = 39,
   parameter int VISC_TW = 38,
   parameter int ACC_W   = 43
) (
   input  logic                     clock,
   input  pipe_ctl_type             ctl,
   input  logic                     viscous_en,
   input  side_type                 side,
   input  logic [FLUX_TW-1:0]       flux_term [NUM_LANES],
   input  logic [VISC_TW-1:0]       visc_term,
   output logic signed [DATA_W-1:0] new_value,
   output logic                     left_factor,
   output logic [1:0]               center_factor,
   output logic                     right_factor,
   output logic                     saturated
);

   logic signed [ACC_W-1:0] f_left, f_center, f_right, f_visc;
   logic signed [ACC_W-1:0] t_left, t_center, t_right, t_visc;
   logic signed [ACC_W-1:0] sum_a_ff, sum_a_in, sum_b_ff, sum_b_in, total;
   side_type                side_ff;
   logic                    overflow;
   logic signed [DATA_W-1:0] value_in, value_ff;
   logic                    sat_in, sat_ff;
   logic                    left_ff, right_ff;
   logic [1:0]              center_ff;

   always_comb begin
      f_left   = ACC_W'(flux_term[LANE_LEFT]);
      f_center = ACC_W'(flux_term[LANE_CENTER]);
      f_right  = ACC_W'(flux_term[LANE_RIGHT]);
      f_visc   = ACC_W'(visc_term);

      case (side.center_f)
         FB_PLUS:  t_center = -f_center;
         FB_MINUS: t_center = f_center;
         default:  t_center = '0;
      endcase
      t_left  = side.left_f ? f_left : '0;
      t_right = side.right_f ? -f_right : '0;
      if (viscous_en) begin
         t_visc = side.lap_neg ? -f_visc : f_visc;
      end else begin
         t_visc = '0;
      end

      sum_a_in = ACC_W'(side.center) + t_center + t_left;
      sum_b_in = t_right + t_visc;
   end

   // clip when the bits above the sign of a 32-bit value disagree
   always_comb begin
      total    = sum_a_ff + sum_b_ff;
      overflow = !((&total[ACC_W-1:DATA_W-1]) || !(|total[ACC_W-1:DATA_W-1]));
      if (overflow) begin
         value_in = total[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                   : {1'b0, {(DATA_W-1){1'b1}}};
      end else begin
         value_in = total[DATA_W-1:0];
      end
      sat_in = overflow;
   end

   always_ff @(posedge clock) begin
      if (ctl.en[ACC_STAGE]) begin
         sum_a_ff <= sum_a_in;
         sum_b_ff <= sum_b_in;
         side_ff  <= side;
      end
      if (ctl.en[ACC_STAGE+1]) begin
         value_ff  <= value_in;
         sat_ff    <= sat_in;
         left_ff   <= side_ff.left_f;
         center_ff <= side_ff.center_f;
         right_ff  <= side_ff.right_f;
      end
   end

   assign new_value     = value_ff;
   assign saturated     = sat_ff;
   assign left_factor   = left_ff;
   assign center_factor = center_ff;
   assign right_factor  = right_ff;

endmodule

[design/burgers_upwind_cell_update.sv]
// Top level of the Burgers upwind cell update; instantiates buc_csr,
// buc_scale_lane and buc_accum, and uses buc_pkg and the two channel interfaces.
//
// One explicit Euler upwind step of Burgers' equation for one cell per item,
// values in signed fixed point with FRAC_BITS fraction bits. The block takes
// one item every clock cycle unless the output stalls, through seven register
// stages: input register, squaring stage, three stages in each scale lane (two
// partial products, then the rounding add), a term-combining stage and the
// saturating output register. Each multiplier sits in a stage of its own to
// keep the stages short; one item per cycle holds because every stage can load
// a new item in every cycle. Every stage carries a valid bit and loads whenever
// it is empty or its successor moves, so empty slots are squeezed out behind a
// stalled output and new items keep entering until the pipeline is full. The
// user must write registers through the APB port only while no item is in
// flight; the block does not enforce this. A missing neighbor at the domain
// edge is sent as zero.
module burgers_upwind_cell_update import buc_pkg::*; #(
   parameter int FRAC_BITS = 28
) (
   input  logic              clock,
   input  logic              reset,
   buc_req_if.sink           req,
   buc_rsp_if.source         rsp,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   // flux term C*v^2/2 drops 2*FRAC_BITS+1 bits, the viscous term FRAC_BITS
   localparam int FLUX_SHIFT = 2 * FRAC_BITS + 1;
   localparam int FLUX_P_W   = CFG_W + SQ_W;
   localparam int FLUX_TW    = (FLUX_P_W > FLUX_SHIFT ? FLUX_P_W - FLUX_SHIFT : 0) + 1;
   localparam int VISC_SHIFT = FRAC_BITS;
   localparam int VISC_P_W   = CFG_W + LAP_W;
   localparam int VISC_TW    = (VISC_P_W > VISC_SHIFT ? VISC_P_W - VISC_SHIFT : 0) + 1;
   localparam int TERM_MAX   = (FLUX_TW > VISC_TW)
                               ? (FLUX_TW > DATA_W ? FLUX_TW : DATA_W)
                               : (VISC_TW > DATA_W ? VISC_TW : DATA_W);
   // center plus four terms: three bits of growth and a sign
   localparam int ACC_W      = TERM_MAX + 4;

   function automatic logic [DATA_W-1:0] mag_of(input logic signed [DATA_W-1:0] v);
      mag_of = v[DATA_W-1] ? DATA_W'(-v) : DATA_W'(v);
   endfunction

   cfg_type      cfg;
   pipe_ctl_type ctl;

   logic [NUM_STAGES-1:0] valid_ff, valid_in;

   // stage 1: neighbor sums, upwind factors, magnitudes, Laplacian
   logic signed [DATA_W:0]  sum_left, sum_right;
   logic signed [LAP_W-1:0] lap;
   side_type                s1_side_in, s1_side_ff;
   logic [DATA_W-1:0]       s1_mag_in [NUM_LANES];
   logic [DATA_W-1:0]       s1_mag_ff [NUM_LANES];
   logic [LAP_W-1:0]        s1_lap_in, s1_lap_ff;

   // stage 2: squares; stages 3 to 5: side data rides along the lanes
   side_type          s2_side_ff, s3_side_ff, s4_side_ff, s5_side_ff;
   logic [SQ_W-1:0]   s2_sq_ff [NUM_LANES];
   logic [LAP_W-1:0]  s2_lap_ff;

   logic [FLUX_TW-1:0] flux_term [NUM_LANES];
   logic [VISC_TW-1:0] visc_term;

   buc_csr #(.FRAC_BITS(FRAC_BITS)) u_csr (
      .clock,
      .reset,
      .psel,
      .penable,
      .pwrite,
      .paddr,
      .pwdata,
      .prdata,
      .pready,
      .cfg
   );

   // Advance a stage when it is empty or its successor advances; the output
   // register advances when it is empty or the result is taken.
   always_comb begin
      ctl.en[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp.ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         ctl.en[k] = !valid_ff[k] || ctl.en[k+1];
      end
      valid_in[0] = ctl.en[0] ? req.valid : valid_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         valid_in[k] = ctl.en[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   assign req.ready = ctl.en[0];
   assign rsp.valid = valid_ff[NUM_STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      sum_left  = (DATA_W+1)'(req.left_old) + (DATA_W+1)'(req.center_old);
      sum_right = (DATA_W+1)'(req.center_old) + (DATA_W+1)'(req.right_old);

      s1_side_in.center = req.center_old;
      s1_side_in.left_f = (sum_left > 0);
      if (sum_left > 0 && sum_right > 0) begin
         s1_side_in.center_f = FB_PLUS;
      end else if (sum_left <= 0 && sum_right <= 0) begin
         s1_side_in.center_f = FB_MINUS;
      end else begin
         s1_side_in.center_f = FB_ZERO;
      end
      s1_side_in.right_f = (sum_right < 0);

      lap = LAP_W'(req.left_old) - (LAP_W'(req.center_old) <<< 1) + LAP_W'(req.right_old);
      s1_side_in.lap_neg = lap[LAP_W-1];
      s1_lap_in = lap[LAP_W-1] ? LAP_W'(-lap) : LAP_W'(lap);

      s1_mag_in[LANE_LEFT]   = mag_of(req.left_old);
      s1_mag_in[LANE_CENTER] = mag_of(req.center_old);
      s1_mag_in[LANE_RIGHT]  = mag_of(req.right_old);
   end

   // payload registers: load on the stage enable, no reset
   always_ff @(posedge clock) begin
      if (ctl.en[0]) begin
         s1_side_ff <= s1_side_in;
         s1_lap_ff  <= s1_lap_in;
         for (int i = 0; i < NUM_LANES; i++) begin
            s1_mag_ff[i] <= s1_mag_in[i];
         end
      end
      if (ctl.en[1]) begin
         s2_side_ff <= s1_side_ff;
         s2_lap_ff  <= s1_lap_ff;
         for (int i = 0; i < NUM_LANES; i++) begin
            s2_sq_ff[i] <= SQ_W'(s1_mag_ff[i]) * SQ_W'(s1_mag_ff[i]);
         end
      end
      if (ctl.en[LANE_STAGE]) begin
         s3_side_ff <= s2_side_ff;
      end
      if (ctl.en[LANE_STAGE+1]) begin
         s4_side_ff <= s3_side_ff;
      end
      if (ctl.en[LANE_STAGE+2]) begin
         s5_side_ff <= s4_side_ff;
      end
   end

   // one flux lane per stencil point; all three use the courant number
   for (genvar i = 0; i < NUM_LANES; i++) begin : g_flux
      buc_scale_lane #(
         .B_W   (SQ_W),
         .SHIFT (FLUX_SHIFT),
         .T_W   (FLUX_TW)
      ) u_lane (
         .clock,
         .ctl,
         .factor  (cfg.courant),
         .operand (s2_sq_ff[i]),
         .term    (flux_term[i])
      );
   end

   buc_scale_lane #(
      .B_W   (LAP_W),
      .SHIFT (VISC_SHIFT),
      .T_W   (VISC_TW)
   ) u_visc (
      .clock,
      .ctl,
      .factor  (cfg.diffusion),
      .operand (s2_lap_ff),
      .term    (visc_term)
   );

   buc_accum #(
      .FLUX_TW (FLUX_TW),
      .VISC_TW (VISC_TW),
      .ACC_W   (ACC_W)
   ) u_accum (
      .clock,
      .ctl,
      .viscous_en    (cfg.viscous_en),
      .side          (s5_side_ff),
      .flux_term,
      .visc_term,
      .new_value     (rsp.new_value),
      .left_factor   (rsp.left_factor),
      .center_factor (rsp.center_factor),
      .right_factor  (rsp.right_factor),
      .saturated     (rsp.saturated)
   );

`ifndef SYNTH
   // a positive left sum rules out both sums being non-positive
   a_left_vs_center: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.left_factor |-> rsp.center_factor != FB_MINUS)
      else $error("left factor set with center factor minus");

   // a negative right sum rules out both sums being positive
   a_right_vs_center: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.right_factor |-> rsp.center_factor != FB_PLUS)
      else $error("right factor set with center factor plus");

   // a clipped result sits at one end of the range
   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.saturated |->
         (rsp.new_value == {1'b0, {(DATA_W-1){1'b1}}} ||
          rsp.new_value == {1'b1, {(DATA_W-1){1'b0}}}))
      else $error("saturated result not at range limit");

   // a stalled output register holds back the stage behind it once that is full
   a_stall_reaches_input: assert property (@(posedge clock) disable iff (reset)
      valid_ff[NUM_STAGES-1] && !rsp.ready && valid_ff[NUM_STAGES-2] |->
         !ctl.en[NUM_STAGES-2])
      else $error("stage advanced into a stalled output register");
`endif

endmodule

[bench/burgers_upwind_cell_update_tb.sv]
// Self-checking bench for the Burgers upwind cell update: random stencils
// on the request channel, results checked against an in-bench fixed-point model.
// Depends on buc_pkg, buc_req_if, buc_rsp_if and burgers_upwind_cell_update.
module burgers_upwind_cell_update_tb import buc_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC_BITS = 28;

   // register indexes on the APB port, 4 bytes apart
   localparam int REG_COURANT   = 0;
   localparam int REG_DIFFUSION = 1;
   localparam int REG_VISCOUS   = 2;
   localparam int REG_SPARE     = 3;  // unmapped, writes must be dropped

   typedef struct packed {
      logic signed [DATA_W-1:0] left_old;
      logic signed [DATA_W-1:0] center_old;
      logic signed [DATA_W-1:0] right_old;
   } stencil_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] new_value;
      logic                     left_factor;
      logic [1:0]               center_factor;
      logic                     right_factor;
      logic                     saturated;
   } cell_update_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              psel    = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite  = 1'b0;
   logic [ADDR_W-1:0] paddr   = '0;
   logic [31:0]       pwdata  = '0;
   logic [31:0]       prdata;
   logic              pready;

   buc_req_if req_ch ();
   buc_rsp_if rsp_ch ();

   burgers_upwind_cell_update #(.FRAC_BITS(FRAC_BITS)) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #5 clock = ~clock;

   // shadow copy of the registers, updated at the edge that writes them
   logic [CFG_W-1:0] courant_q   = CFG_W'(1) << FRAC_BITS;
   logic [CFG_W-1:0] diffusion_q = '0;
   logic             viscous_q   = 1'b0;

   stencil_type     stencil_queue[$];      // items waiting for the driver
   cell_update_type predicted_updates[$];  // one per accepted item, oldest first
   stencil_type     cur_stencil;
   bit              no_idle = 1'b0;        // suspend random idling on both sides
   int              mismatches = 0;
   int              results_seen = 0;

   // Flux term C*v^2/2, rounded half away from zero; always non-negative.
   function automatic logic [95:0] flux_term(logic signed [DATA_W-1:0] v);
      logic [31:0] m;
      logic [95:0] p;
      m = v[31] ? -v : v;
      p = courant_q * m * m;
      p = p + (96'd1 << (2 * FRAC_BITS));
      return p >> (2 * FRAC_BITS + 1);
   endfunction

   // Expected result for one stencil under the current shadow registers.
   function automatic cell_update_type predict_cell_update(stencil_type s);
      cell_update_type    u;
      logic signed [32:0] sum_l;
      logic signed [32:0] sum_r;
      logic signed [34:0] lap;
      logic [34:0]        lap_m;
      logic [95:0]        visc;
      logic signed [127:0] acc;

      sum_l = s.left_old + s.center_old;
      sum_r = s.center_old + s.right_old;
      u.left_factor  = sum_l > 0;
      u.right_factor = sum_r < 0;
      if (sum_l > 0 && sum_r > 0) begin
         u.center_factor = FB_PLUS;
      end else if (sum_l <= 0 && sum_r <= 0) begin
         u.center_factor = FB_MINUS;
      end else begin
         u.center_factor = FB_ZERO;
      end

      // center minus b*F(center) minus a*F(left) minus c*F(right), a in {-1,0}
      acc = s.center_old;
      if (u.center_factor == FB_PLUS) begin
         acc = acc - $signed({32'd0, flux_term(s.center_old)});
      end else if (u.center_factor == FB_MINUS) begin
         acc = acc + $signed({32'd0, flux_term(s.center_old)});
      end
      if (u.left_factor) begin
         acc = acc + $signed({32'd0, flux_term(s.left_old)});
      end
      if (u.right_factor) begin
         acc = acc - $signed({32'd0, flux_term(s.right_old)});
      end
      if (viscous_q) begin
         lap   = s.left_old - 2 * s.center_old + s.right_old;
         lap_m = lap[34] ? -lap : lap;
         visc  = (diffusion_q * lap_m + (96'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
         acc   = lap[34] ? acc - $signed({32'd0, visc}) : acc + $signed({32'd0, visc});
      end

      // clip when bits above the 32-bit sign are not a pure sign extension
      u.saturated = acc[127:31] != {97{acc[127]}};
      if (u.saturated) begin
         u.new_value = acc[127] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else begin
         u.new_value = acc[31:0];
      end
      return u;
   endfunction

   // Q4.28 value biased toward extremes and toward small magnitudes.
   function automatic logic signed [DATA_W-1:0] random_q_value();
      logic [31:0] mag;
      case ($urandom_range(7))
         0: return 32'sh7fff_ffff;
         1: return 32'sh8000_0000;
         2, 3: return $urandom;
         default: begin
            mag = $urandom_range(32'h3fff_ffff, 0) >> $urandom_range(16, 0);
            return $urandom_range(1) ? -mag : mag;
         end
      endcase
   endfunction

   task automatic push_stencil(logic [31:0] l, logic [31:0] c, logic [31:0] r);
      stencil_type s;
      s.left_old   = l;
      s.center_old = c;
      s.right_old  = r;
      stencil_queue.push_back(s);
   endtask

   // Extremes, both boundaries, zero neighbor sums, every center factor code.
   task automatic queue_directed();
      push_stencil(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      push_stencil(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      push_stencil(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      push_stencil(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
      push_stencil(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
      push_stencil(32'h0000_0000, 32'h1000_0000, 32'h0000_0000);   // both neighbors outside
      push_stencil(32'h1000_0000, 32'hf000_0000, 32'h1000_0000);   // both sums exactly zero
      push_stencil(32'hd000_0000, 32'h2000_0000, 32'hf800_0000);   // left sum < 0, right > 0
      push_stencil(32'h3000_0000, 32'he000_0000, 32'h0800_0000);   // left sum > 0, right < 0
      push_stencil(32'h0000_0000, 32'h7fff_ffff, 32'h0000_0000);
      push_stencil(32'h0000_0000, 32'h8000_0000, 32'h0000_0000);
      push_stencil(32'h0000_0001, 32'hffff_ffff, 32'h0000_0001);   // rounding of tiny terms
      push_stencil(32'h0000_0001, 32'h0000_0000, 32'hffff_ffff);
   endtask

   task automatic queue_random(int count);
      stencil_type s;
      repeat (count) begin
         s.left_old   = random_q_value();
         s.center_old = random_q_value();
         s.right_old  = random_q_value();
         // land on the domain edge or on a zero neighbor sum now and then
         case ($urandom_range(9))
            0: s.left_old = '0;
            1: s.right_old = '0;
            2: s.left_old = -s.center_old;
            3: s.right_old = -s.center_old;
            default: ;
         endcase
         stencil_queue.push_back(s);
      end
   endtask

   // Hold until every queued item is accepted and every result has come back;
   // look between edges so that the driver and monitor updates have settled.
   task automatic wait_idle();
      while (stencil_queue.size() != 0 || req_ch.valid || predicted_updates.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // APB write: setup cycle, then access cycle; the shadow follows the write edge.
   task automatic csr_write(int idx, logic [31:0] data);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_W'(idx * 4);
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_COURANT:   courant_q   = data[CFG_W-1:0];
         REG_DIFFUSION: diffusion_q = data[CFG_W-1:0];
         REG_VISCOUS:   viscous_q   = data[0];
         default: ;  // unmapped index, the block drops it
      endcase
   endtask

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: result %0d %s mismatch, expected %h, actual %h",
                  $realtime, results_seen, name, want, got);
         mismatches++;
      end
   endtask

   // Driver: keep valid up until the item is taken, then maybe idle at random.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         // predict at acceptance: registers cannot change while items are in flight
         if (req_ch.valid && req_ch.ready) begin
            predicted_updates.push_back(predict_cell_update(cur_stencil));
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (stencil_queue.size() != 0 && (no_idle || $urandom_range(99) >= 17)) begin
               cur_stencil = stencil_queue.pop_front();
               req_ch.valid      <= 1'b1;
               req_ch.left_old   <= cur_stencil.left_old;
               req_ch.center_old <= cur_stencil.center_old;
               req_ch.right_old  <= cur_stencil.right_old;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: take results, compare against the oldest prediction, stall at random.
   always @(posedge clock) begin
      cell_update_type got;
      cell_update_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.new_value     = rsp_ch.new_value;
            got.left_factor   = rsp_ch.left_factor;
            got.center_factor = rsp_ch.center_factor;
            got.right_factor  = rsp_ch.right_factor;
            got.saturated     = rsp_ch.saturated;
            if (predicted_updates.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h", $realtime, got);
               mismatches++;
            end else begin
               want = predicted_updates.pop_front();
               check_field("new_value", want.new_value, got.new_value);
               check_field("left_factor", want.left_factor, got.left_factor);
               check_field("center_factor", want.center_factor, got.center_factor);
               check_field("right_factor", want.right_factor, got.right_factor);
               check_field("saturated", want.saturated, got.saturated);
            end
            results_seen++;
         end
         rsp_ch.ready <= no_idle || $urandom_range(99) >= 17;
      end
   end

   // Stimulus and phases; registers are only touched between drained phases.
   initial begin
      req_ch.valid      = 1'b0;
      req_ch.left_old   = '0;
      req_ch.center_old = '0;
      req_ch.right_old  = '0;
      rsp_ch.ready      = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset values: C = 1.0, no viscous term
      queue_directed();
      queue_random(140);
      wait_idle();

      // top extremes; all-ones data checks that bits above each width are dropped
      csr_write(REG_COURANT, 32'hffff_ffff);
      csr_write(REG_DIFFUSION, 32'hffff_ffff);
      csr_write(REG_VISCOUS, 32'hffff_ffff);
      csr_write(REG_SPARE, 32'h5555_5555);
      queue_directed();
      queue_random(70);
      wait_idle();  // sender stops until the pipeline has fully drained
      queue_random(70);
      wait_idle();

      // zero coefficients with the viscous path on, at full rate on both sides
      csr_write(REG_COURANT, 32'h0);
      csr_write(REG_DIFFUSION, 32'h0);
      no_idle = 1'b1;
      queue_random(150);
      wait_idle();
      no_idle = 1'b0;

      // random settings, mostly C up to 1.0 so that not everything clips
      repeat (3) begin
         csr_write(REG_COURANT, $urandom_range(1) ? $urandom : $urandom_range(32'h1000_0000, 0));
         csr_write(REG_DIFFUSION, $urandom_range(1) ? $urandom : $urandom_range(32'h0800_0000, 0));
         csr_write(REG_VISCOUS, $urandom);
         queue_random(110);
         wait_idle();
      end

      repeat (3 * NUM_STAGES) @(posedge clock);
      if (mismatches == 0 && predicted_updates.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest correct run.
   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
